>>> rtl/gfbe_pkg.sv
// Shared types, constants and GF(256) helpers for the bit-sliced encode accumulator.
// No dependencies; used by every module under rtl/.
package gfbe_pkg;

	localparam int MAX_LANES_DEF = 256;    // default accumulator depth
	localparam int OUT_DEPTH     = 3;      // result queue entries
	localparam int OUT_LVL_W     = 2;      // holds 0..OUT_DEPTH
	localparam int APB_ADDR_W    = 3;      // byte address of the only register
	localparam int LANES_W       = 9;      // width of lanes_in_use

	localparam logic [7:0] GF_REDUCE = 8'h87;   // x^8 = x^7+x^2+x+1 (poly 0x187)

	// register index codes (word address bit 2 of paddr)
	localparam logic REG_LANES_IN_USE = 1'b0;

	// one product ready for the accumulate stage
	typedef struct packed {
		logic [63:0] prod;
		logic        first;      // overwrite instead of accumulate
		logic        emit;       // deliver the updated entry
		logic        last_lane;  // final byte position of the block
	} acc_req_t;

	// one result word on its way out
	typedef struct packed {
		logic        last_lane;
		logic [7:0]  lane;
		logic [63:0] word;
	} result_t;

	function automatic logic [7:0] gf_double(input logic [7:0] s);
		logic [7:0] r;
		r = {s[6:0], 1'b0};
		if (s[7]) begin
			r = r ^ GF_REDUCE;
		end
		return r;
	endfunction

endpackage

>>> rtl/gfbe_bitmatrix.sv
// Bit-matrix product of one GF(256) coefficient with eight packed source bytes.
// Depends on gfbe_pkg (gf_double).
module gfbe_bitmatrix (
	input  logic [7:0]  coef,
	input  logic [63:0] word,
	output logic [63:0] prod
);

	logic [7:0] slice [8];

	// expand the coefficient into its eight doubled slices
	always_comb begin
		slice[0] = coef;
		for (int y = 1; y < 8; y++) begin
			slice[y] = gfbe_pkg::gf_double(slice[y-1]);
		end
	end

	// byte y: XOR of source bytes selected by slice y
	always_comb begin
		for (int y = 0; y < 8; y++) begin
			logic [7:0] acc;
			acc = '0;
			for (int b = 0; b < 8; b++) begin
				acc = acc ^ (word[8*b +: 8] & {8{slice[y][b]}});
			end
			prod[8*y +: 8] = acc;
		end
	end

endmodule

>>> rtl/gfbe_acc_mem.sv
// Accumulator memory with read-modify-write stage and same-lane forwarding.
// Depends on gfbe_pkg (acc_req_t, result_t).
module gfbe_acc_mem #(
	parameter int MAX_LANES = gfbe_pkg::MAX_LANES_DEF,
	parameter int LW        = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  gfbe_pkg::acc_req_t  req,
	input  logic [LW-1:0]       req_lane,
	output logic                res_valid,
	output gfbe_pkg::result_t   res
);

	logic [63:0] mem [MAX_LANES];

	logic               valid_s1;
	gfbe_pkg::acc_req_t req_s1;
	logic [LW-1:0]      lane_s1;
	logic [63:0]        rdata_s1;
	logic [63:0]        next_word;

	assign next_word = req_s1.first ? req_s1.prod : (rdata_s1 ^ req_s1.prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			req_s1  <= req;
			lane_s1 <= req_lane;
		end
	end

	// write back the updated entry; forward it when the next word hits the same lane
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem[lane_s1] <= next_word;
		end
		if (req_valid) begin
			if (valid_s1 && (lane_s1 == req_lane)) begin
				rdata_s1 <= next_word;
			end else begin
				rdata_s1 <= mem[req_lane];
			end
		end
	end

	assign res_valid     = valid_s1 && req_s1.emit;
	assign res.word      = next_word;
	assign res.lane      = 8'(lane_s1);
	assign res.last_lane = req_s1.last_lane;

endmodule

>>> rtl/gfbe_result_fifo.sv
// Small register queue that holds finished result words until taken.
// Depends on gfbe_pkg (result_t, OUT_DEPTH, OUT_LVL_W).
module gfbe_result_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  gfbe_pkg::result_t                 din,
	input  logic                              pop,
	output logic                              valid,
	output gfbe_pkg::result_t                 dout,
	output logic [gfbe_pkg::OUT_LVL_W-1:0]    level
);

	localparam int PW = $clog2(gfbe_pkg::OUT_DEPTH);

	gfbe_pkg::result_t ent_q [gfbe_pkg::OUT_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [gfbe_pkg::OUT_LVL_W-1:0] level_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(gfbe_pkg::OUT_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   level_q <= level_q + gfbe_pkg::OUT_LVL_W'(1);
				2'b01:   level_q <= level_q - gfbe_pkg::OUT_LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	assign valid = (level_q != '0);
	assign dout  = ent_q[rd_ptr_q];
	assign level = level_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= gfbe_pkg::OUT_LVL_W'(gfbe_pkg::OUT_DEPTH))
		else $error("result queue level beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q == gfbe_pkg::OUT_LVL_W'(gfbe_pkg::OUT_DEPTH)) && !pop |-> !push)
		else $error("push into full result queue");

endmodule

>>> rtl/gfbe_encode_top_dummy_guard.sv
// Holds the lanes_in_use register and the read mux for the APB port of the encode accumulator.
// Depends on gfbe_pkg (register codes, widths).
module gfbe_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gfbe_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic [gfbe_pkg::LANES_W-1:0]      lanes_in_use
);

	logic [gfbe_pkg::LANES_W-1:0] lanes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= gfbe_pkg::LANES_W'(1);
		end else if (psel && penable && pwrite && (paddr[2] == gfbe_pkg::REG_LANES_IN_USE)) begin
			lanes_q <= pwdata[gfbe_pkg::LANES_W-1:0];
		end
	end

	assign prdata       = (paddr[2] == gfbe_pkg::REG_LANES_IN_USE) ? 32'(lanes_q) : '0;
	assign lanes_in_use = lanes_q;

endmodule

>>> rtl/gf256_bitsliced_encode_accumulator.sv
// Top level of the Cauchy Reed-Solomon bit-matrix encode accumulator over GF(256).
// Depends on gfbe_pkg, gfbe_bitmatrix, gfbe_acc_mem, gfbe_result_fifo, gfbe_cfg_regs.
//
// Builds one recovery block from source data sent column by column, one byte position
// (lane) per input word. Each word carries a GF(256) coefficient and the eight source
// bytes of the current lane; the block forms their bit-matrix product (polynomial 0x187)
// and writes it (first column) or XORs it (other columns) into a 64-bit accumulator entry
// per lane. On the last column the updated entry leaves on the output stream together with
// its lane and a flag for the final lane of the block. The lane counter advances on every
// accepted word and wraps after lanes_in_use lanes (0 acts as 1, values above MAX_LANES
// act as MAX_LANES); rewriting lanes_in_use leaves the counter where it is. The block takes
// one word per clock cycle, sustained while input ready is high: the product is formed as
// the word enters while the accumulator entry is read, and the next cycle merges and writes
// it back through the memory's one write port. A word that hits the lane still being
// written back gets the fresh value forwarded, so back-to-back words on the same lane are
// fine. Results wait in a three-entry queue; input ready counts the queued words plus the
// one being merged, so with a result on every cycle an output stall holds the input off
// from the next cycle on, while words that emit nothing only wait once the queue is full.
// Accumulator entries are not cleared at reset: the first word for every lane after reset
// must carry first_column, and there is no clearing pass. Configuration writes belong to
// idle periods only.
module gf256_bitsliced_encode_accumulator #(
	parameter int MAX_LANES = gfbe_pkg::MAX_LANES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// tdata: [7:0] coefficient, [71:8] data_word; tuser: first_column; tlast: last_column
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [71:0]                       s_axis_tdata,
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	// tdata: [63:0] recovery_word, [71:64] lane; tlast: last_lane
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [71:0]                       m_axis_tdata,
	output logic                              m_axis_tlast,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gfbe_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int CW = ((LW > gfbe_pkg::LANES_W) ? LW : gfbe_pkg::LANES_W) + 1;

	logic [gfbe_pkg::LANES_W-1:0] lanes_in_use;
	logic [LW-1:0]                lane_q;
	logic [CW-1:0]                lim;
	logic                         last_lane;
	logic                         accept;
	logic [63:0]                  prod;
	gfbe_pkg::acc_req_t           req;
	logic                         res_valid;
	gfbe_pkg::result_t            res;
	gfbe_pkg::result_t            head;
	logic [gfbe_pkg::OUT_LVL_W-1:0] level;
	logic [gfbe_pkg::OUT_LVL_W:0]   committed;

	assign pready = 1'b1;

	gfbe_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.lanes_in_use (lanes_in_use)
	);

	// clamp the lane count into 1..MAX_LANES
	always_comb begin
		lim = CW'(lanes_in_use);
		if (lanes_in_use == '0) begin
			lim = CW'(1);
		end else if (lim > CW'(MAX_LANES)) begin
			lim = CW'(MAX_LANES);
		end
	end

	assign last_lane = (CW'(lane_q) + CW'(1)) >= lim;

	// hold off input only when every queue slot is spoken for
	assign committed     = (gfbe_pkg::OUT_LVL_W + 1)'(level) + (gfbe_pkg::OUT_LVL_W + 1)'(res_valid);
	assign s_axis_tready = committed < (gfbe_pkg::OUT_LVL_W + 1)'(gfbe_pkg::OUT_DEPTH);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// advance the lane, wrap after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
		end else if (accept) begin
			lane_q <= last_lane ? '0 : lane_q + LW'(1);
		end
	end

	gfbe_bitmatrix u_bitmatrix (
		.coef (s_axis_tdata[7:0]),
		.word (s_axis_tdata[71:8]),
		.prod (prod)
	);

	assign req.prod      = prod;
	assign req.first     = s_axis_tuser;
	assign req.emit      = s_axis_tlast;
	assign req.last_lane = last_lane;

	gfbe_acc_mem #(
		.MAX_LANES (MAX_LANES),
		.LW        (LW)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (accept),
		.req       (req),
		.req_lane  (lane_q),
		.res_valid (res_valid),
		.res       (res)
	);

	gfbe_result_fifo u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.pop    (m_axis_tvalid && m_axis_tready),
		.valid  (m_axis_tvalid),
		.dout   (head),
		.level  (level)
	);

	assign m_axis_tdata = {head.lane, head.word};
	assign m_axis_tlast = head.last_lane;

	a_lane_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(lane_q) < CW'(MAX_LANES))
		else $error("lane counter beyond accumulator depth");

	a_wrap_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_lane |=> lane_q == '0)
		else $error("lane counter did not wrap after the last lane");

	a_ready_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tlast |=>
			(gfbe_pkg::OUT_LVL_W + 1)'(level) < (gfbe_pkg::OUT_LVL_W + 1)'(gfbe_pkg::OUT_DEPTH))
		else $error("result committed without a free queue slot");

endmodule
